// ===== hdl/bcmp_pkg.sv =====
`default_nettype none

package bcmp_pkg;

    // datapath widths
    localparam int FINE_W = 24;
    localparam int NUM_W  = 67;
    localparam int DIV_W  = 42;

    // compensation constants
    localparam logic signed [24:0] PRES_T_OFFSET  = 25'sd128000;
    localparam logic [20:0]        RAW_FULL_SCALE = 21'd1048576;
    localparam logic [11:0]        NUM_SCALE      = 12'd3125;
    localparam logic signed [57:0] DIV_BIAS       = 58'sd140737488355328;

    // one raw reading pair
    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } sample_t;

    // one compensated result
    typedef struct packed {
        logic signed [31:0] fine_temperature;
        logic signed [15:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic               pressure_invalid;
    } result_t;

    // calibration register file
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [31:0] p2_p3;
        logic [31:0] p4_p5;
        logic [31:0] p6_p7;
        logic [31:0] p8_p9;
    } cal_t;

    // register indexes
    typedef enum logic [2:0] {
        CFG_T1    = 3'd0,
        CFG_T2    = 3'd1,
        CFG_T3    = 3'd2,
        CFG_P1    = 3'd3,
        CFG_P2_P3 = 3'd4,
        CFG_P4_P5 = 3'd5,
        CFG_P6_P7 = 3'd6,
        CFG_P8_P9 = 3'd7
    } cfg_idx_t;

    // work item handed from front to back
    typedef struct packed {
        logic signed [FINE_W-1:0] fine;
        logic signed [15:0]       cent;
        logic signed [NUM_W-1:0]  num;
        logic signed [DIV_W-1:0]  dvs;
    } fq_t;

endpackage

`default_nettype wire

// ===== hdl/bcmp_front.sv =====
`default_nettype none

module bcmp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  bcmp_pkg::cal_t    cal,
    input  logic             sample_valid,
    output logic             sample_ready,
    input  bcmp_pkg::sample_t sample,
    input  logic             q_full,
    output logic             q_push,
    output bcmp_pkg::fq_t     q_item
);
    import bcmp_pkg::*;

    localparam int NSTG = 7;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic            adv;

    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6;
    logic [15:0]        p1;

    logic signed [17:0] ta;
    logic signed [16:0] diff;

    logic signed [33:0] s1_pa_reg;
    logic signed [33:0] s1_dd_reg;
    logic [19:0]        s1_rp_reg;

    logic signed [21:0] dsh;
    logic signed [22:0] s2_fp1_reg;
    logic signed [37:0] s2_dt_reg;
    logic [19:0]        s2_rp_reg;

    logic signed [FINE_W-1:0] s3_fine_reg;
    logic [19:0]              s3_rp_reg;

    logic signed [24:0] v;
    logic signed [49:0] vv_full;
    logic signed [19:0] cent_full;
    logic signed [15:0] cent_sat;
    logic [46:0]              s4_vv_reg;
    logic signed [40:0]       s4_vp5_reg;
    logic signed [40:0]       s4_vp2_reg;
    logic signed [FINE_W-1:0] s4_fine_reg;
    logic signed [15:0]       s4_cent_reg;
    logic [19:0]              s4_rp_reg;

    logic signed [47:0]       vvs;
    logic signed [63:0]       s5_t6_reg;
    logic signed [63:0]       s5_t3_reg;
    logic signed [40:0]       s5_vp5_reg;
    logic signed [40:0]       s5_vp2_reg;
    logic signed [FINE_W-1:0] s5_fine_reg;
    logic signed [15:0]       s5_cent_reg;
    logic [19:0]              s5_rp_reg;

    logic signed [56:0]       u;
    logic signed [65:0]       s6_w_reg;
    logic signed [57:0]       s6_a_reg;
    logic signed [FINE_W-1:0] s6_fine_reg;
    logic signed [15:0]       s6_cent_reg;
    logic [19:0]              s6_rp_reg;

    logic [20:0]              ofs;
    logic signed [28:0]       a_hi;
    logic signed [16:0]       p1s;
    logic signed [NUM_W-1:0]  s7_num_reg;
    logic [44:0]              s7_mlo_reg;
    logic signed [45:0]       s7_mhi_reg;
    logic signed [FINE_W-1:0] s7_fine_reg;
    logic signed [15:0]       s7_cent_reg;
    logic signed [74:0]       msum;

    // calibration words
    assign p1 = cal.p1;
    assign t2 = $signed(cal.t2);
    assign t3 = $signed(cal.t3);
    assign p2 = $signed(cal.p2_p3[15:0]);
    assign p3 = $signed(cal.p2_p3[31:16]);
    assign p4 = $signed(cal.p4_p5[15:0]);
    assign p5 = $signed(cal.p4_p5[31:16]);
    assign p6 = $signed(cal.p6_p7[15:0]);

    // pipeline moves as one unless the tail waits on a full queue
    assign adv          = !(vld_reg[NSTG-1] && q_full);
    assign sample_ready = adv;
    assign q_push       = vld_reg[NSTG-1] && !q_full;
    assign vld_next     = {vld_reg[NSTG-2:0], sample_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // stage 1 operands
    assign ta   = $signed({1'b0, sample.raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
    assign diff = $signed({1'b0, sample.raw_temperature[19:4]}) - $signed({1'b0, cal.t1});

    // stage 2 operands
    assign dsh = 22'(s1_dd_reg >>> 12);

    // stage 4 operands
    assign v         = 25'(s3_fine_reg) - PRES_T_OFFSET;
    assign vv_full   = 50'(v * v);
    assign cent_full = 20'((28'(s3_fine_reg) * 28'sd5 + 28'sd128) >>> 8);

    always_comb
    begin
        if (cent_full > 20'sd32767)
            cent_sat = 16'sh7FFF;
        else if (cent_full < -20'sd32768)
            cent_sat = 16'sh8000;
        else
            cent_sat = 16'(cent_full);
    end

    // stage 5 operand
    assign vvs = $signed({1'b0, s4_vv_reg});

    // stage 6 operand
    assign u = 57'(s5_t3_reg >>> 8) + (57'(s5_vp2_reg) <<< 12);

    // stage 7 operands
    assign ofs  = RAW_FULL_SCALE - {1'b0, s6_rp_reg};
    assign a_hi = $signed(s6_a_reg[57:29]);
    assign p1s  = $signed({1'b0, p1});

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pa_reg   <= 34'(ta * t2);
            s1_dd_reg   <= 34'(diff * diff);
            s1_rp_reg   <= sample.raw_pressure;

            s2_fp1_reg  <= 23'(s1_pa_reg >>> 11);
            s2_dt_reg   <= 38'(dsh * t3);
            s2_rp_reg   <= s1_rp_reg;

            s3_fine_reg <= FINE_W'(s2_fp1_reg) + FINE_W'(s2_dt_reg >>> 14);
            s3_rp_reg   <= s2_rp_reg;

            s4_vv_reg   <= vv_full[46:0];
            s4_vp5_reg  <= 41'(v * p5);
            s4_vp2_reg  <= 41'(v * p2);
            s4_fine_reg <= s3_fine_reg;
            s4_cent_reg <= cent_sat;
            s4_rp_reg   <= s3_rp_reg;

            s5_t6_reg   <= 64'(vvs * p6);
            s5_t3_reg   <= 64'(vvs * p3);
            s5_vp5_reg  <= s4_vp5_reg;
            s5_vp2_reg  <= s4_vp2_reg;
            s5_fine_reg <= s4_fine_reg;
            s5_cent_reg <= s4_cent_reg;
            s5_rp_reg   <= s4_rp_reg;

            s6_w_reg    <= 66'(s5_t6_reg) + (66'(s5_vp5_reg) <<< 17) + (66'(p4) <<< 35);
            s6_a_reg    <= 58'(u) + DIV_BIAS;
            s6_fine_reg <= s5_fine_reg;
            s6_cent_reg <= s5_cent_reg;
            s6_rp_reg   <= s5_rp_reg;

            s7_num_reg  <= (NUM_W'($signed({1'b0, ofs})) <<< 31) - NUM_W'(s6_w_reg);
            s7_mlo_reg  <= 45'(s6_a_reg[28:0] * p1);
            s7_mhi_reg  <= 46'(a_hi * p1s);
            s7_fine_reg <= s6_fine_reg;
            s7_cent_reg <= s6_cent_reg;
        end
    end

    // divisor from the split product
    assign msum = (75'(s7_mhi_reg) <<< 29) + 75'($signed({1'b0, s7_mlo_reg}));

    always_comb
    begin
        q_item.fine = s7_fine_reg;
        q_item.cent = s7_cent_reg;
        q_item.num  = s7_num_reg;
        q_item.dvs  = DIV_W'(msum >>> 33);
    end

endmodule

`default_nettype wire

// ===== hdl/bcmp_fifo.sv =====
`default_nettype none

module bcmp_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bcmp_pkg::fq_t push_item,
    output logic          full,
    input  logic          pop,
    output bcmp_pkg::fq_t pop_item,
    output logic          empty
);
    import bcmp_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fq_t              slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// ===== hdl/bcmp_back.sv =====
`default_nettype none

module bcmp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  bcmp_pkg::cal_t    cal,
    input  logic              q_empty,
    output logic              q_pop,
    input  bcmp_pkg::fq_t     q_item,
    output logic              result_valid,
    input  logic              result_ready,
    output bcmp_pkg::result_t result
);
    import bcmp_pkg::*;

    localparam int Q_W   = 47;
    localparam int N_W   = NUM_W + 12;
    localparam int ST_P1 = Q_W + 2;
    localparam int NST   = ST_P1 + 4;
    localparam logic [Q_W-1:0] Q_CAP = Q_W'(1) << (Q_W - 1);

    typedef struct packed {
        logic signed [FINE_W-1:0] fine;
        logic signed [15:0]       cent;
        logic                     invalid;
        logic                     neg;
    } side_t;

    typedef struct packed {
        side_t            side;
        logic             ovf;
        logic [DIV_W-1:0] dvs;
        logic [DIV_W-1:0] rem;
        logic [Q_W-1:0]   nq;
    } div_t;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic           adv;

    logic signed [15:0] p7, p8, p9;

    logic [NUM_W-1:0] nabs;
    logic [DIV_W-1:0] dabs;
    logic [N_W-1:0]   b0_n_reg;
    logic [DIV_W-1:0] b0_d_reg;
    side_t            b0_side_reg;
    side_t            side_in;

    div_t div_reg  [Q_W+1];
    div_t div_next [Q_W+1];

    logic [Q_W-1:0]     qmag;
    logic signed [47:0] p1_q_reg;
    side_t              p1_side_reg;

    logic signed [34:0] s;
    logic signed [47:0] p2_q_reg;
    logic signed [34:0] p2_s_reg;
    logic signed [50:0] p2_a9_reg;
    logic signed [63:0] p2_c8p_reg;
    side_t              p2_side_reg;

    logic signed [25:0] hi9;
    logic signed [25:0] lo9;
    logic signed [47:0] p3_q_reg;
    logic signed [44:0] p3_c8_reg;
    logic signed [60:0] p3_mhi_reg;
    logic signed [60:0] p3_mlo_reg;
    side_t              p3_side_reg;

    logic signed [61:0] c9;
    logic signed [62:0] p4_sum_reg;
    side_t              p4_side_reg;

    logic signed [55:0] f;
    logic [31:0]        pres;
    result_t            res_next;
    result_t            result_reg;
    logic               result_valid_reg;

    assign p7 = $signed(cal.p6_p7[31:16]);
    assign p8 = $signed(cal.p8_p9[15:0]);
    assign p9 = $signed(cal.p8_p9[31:16]);

    // whole back pipeline advances when the output register can move
    assign adv          = !result_valid_reg || result_ready;
    assign q_pop        = adv && !q_empty;
    assign vld_next     = {vld_reg[NST-2:0], !q_empty};
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg          <= vld_next;
            result_valid_reg <= vld_reg[NST-1];
        end
    end

    // magnitudes and sign of the quotient
    always_comb
    begin
        nabs            = q_item.num[NUM_W-1] ? NUM_W'(-q_item.num) : NUM_W'(q_item.num);
        dabs            = q_item.dvs[DIV_W-1] ? DIV_W'(-q_item.dvs) : DIV_W'(q_item.dvs);
        side_in.fine    = q_item.fine;
        side_in.cent    = q_item.cent;
        side_in.invalid = (q_item.dvs == '0);
        side_in.neg     = q_item.num[NUM_W-1] ^ q_item.dvs[DIV_W-1];
    end

    // restoring divider, one quotient bit per stage
    always_comb
    begin
        logic [DIV_W:0] rem_ext;
        logic [DIV_W:0] rem_sub;
        logic           ge;

        div_next[0].side = b0_side_reg;
        div_next[0].ovf  = DIV_W'(b0_n_reg[N_W-1:Q_W]) >= b0_d_reg;
        div_next[0].dvs  = b0_d_reg;
        div_next[0].rem  = DIV_W'(b0_n_reg[N_W-1:Q_W]);
        div_next[0].nq   = b0_n_reg[Q_W-1:0];
        for (int k = 0; k < Q_W; k++)
        begin
            rem_ext           = {div_reg[k].rem, div_reg[k].nq[Q_W-1]};
            rem_sub           = rem_ext - {1'b0, div_reg[k].dvs};
            ge                = rem_ext >= {1'b0, div_reg[k].dvs};
            div_next[k+1]     = div_reg[k];
            div_next[k+1].rem = ge ? rem_sub[DIV_W-1:0] : rem_ext[DIV_W-1:0];
            div_next[k+1].nq  = {div_reg[k].nq[Q_W-2:0], ge};
        end
    end

    // quotient clamp
    assign qmag = (div_reg[Q_W].ovf || div_reg[Q_W].nq > Q_CAP) ? Q_CAP : div_reg[Q_W].nq;

    // second-order terms
    assign s   = 35'(p1_q_reg >>> 13);
    assign hi9 = 26'(p2_a9_reg >>> 25);
    assign lo9 = $signed({1'b0, p2_a9_reg[24:0]});
    assign c9  = 62'(p3_mhi_reg) + 62'(p3_mlo_reg >>> 25);

    // final pressure with saturation
    assign f = 56'(p4_sum_reg >>> 8) + (56'(p7) <<< 4);

    always_comb
    begin
        if (f[55])
            pres = '0;
        else if (f[54:32] != '0)
            pres = '1;
        else
            pres = f[31:0];
        res_next.fine_temperature  = 32'(p4_side_reg.fine);
        res_next.temperature_centi = p4_side_reg.cent;
        res_next.pressure_invalid  = p4_side_reg.invalid;
        res_next.pressure_q24_8    = p4_side_reg.invalid ? '0 : pres;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b0_n_reg    <= N_W'(nabs) * N_W'(NUM_SCALE);
            b0_d_reg    <= dabs;
            b0_side_reg <= side_in;

            for (int k = 0; k <= Q_W; k++)
                div_reg[k] <= div_next[k];

            p1_q_reg    <= div_reg[Q_W].side.neg ? -48'(qmag) : 48'(qmag);
            p1_side_reg <= div_reg[Q_W].side;

            p2_q_reg    <= p1_q_reg;
            p2_s_reg    <= s;
            p2_a9_reg   <= 51'(s * p9);
            p2_c8p_reg  <= 64'(p1_q_reg * p8);
            p2_side_reg <= p1_side_reg;

            p3_q_reg    <= p2_q_reg;
            p3_c8_reg   <= 45'(p2_c8p_reg >>> 19);
            p3_mhi_reg  <= 61'(hi9 * p2_s_reg);
            p3_mlo_reg  <= 61'(lo9 * p2_s_reg);
            p3_side_reg <= p2_side_reg;

            p4_sum_reg  <= 63'(p3_q_reg) + 63'(c9) + 63'(p3_c8_reg);
            p4_side_reg <= p3_side_reg;

            result_reg  <= res_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/barometer_compensation_core.sv =====
// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------------
// sample    | sample_valid, sample_ready | sample (raw temperature, pressure)
// result    | result_valid, result_ready | result (fine, centi, q24.8, invalid)
// cfg       | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// one transaction per cycle in and out unless stalled; samples pass 7 front stages, the
// queue, then 53 back stages led by a 47-stage restoring divider and the output register.
// rst_n clears valid state and all calibration registers to zero.
// front and back stall apart: a full queue holds the front, a held result holds the back.
// cfg_ready is always high.
`default_nettype none

module barometer_compensation_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_ready,
    input  bcmp_pkg::sample_t   sample,
    output logic                result_valid,
    input  logic                result_ready,
    output bcmp_pkg::result_t   result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  bcmp_pkg::cfg_idx_t  cfg_index,
    input  logic [31:0]         cfg_data
);
    import bcmp_pkg::*;

    cal_t cal_reg;
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_empty;
    fq_t  q_in;
    fq_t  q_out;

    assign cfg_ready = 1'b1;

    // calibration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cal_reg <= '0;
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_T1:    cal_reg.t1    <= cfg_data[15:0];
                CFG_T2:    cal_reg.t2    <= cfg_data[15:0];
                CFG_T3:    cal_reg.t3    <= cfg_data[15:0];
                CFG_P1:    cal_reg.p1    <= cfg_data[15:0];
                CFG_P2_P3: cal_reg.p2_p3 <= cfg_data;
                CFG_P4_P5: cal_reg.p4_p5 <= cfg_data;
                CFG_P6_P7: cal_reg.p6_p7 <= cfg_data;
                CFG_P8_P9: cal_reg.p8_p9 <= cfg_data;
                default:   cal_reg       <= cal_reg;
            endcase
        end
    end

    // temperature and divider operands
    bcmp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cal          (cal_reg),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (q_in)
    );

    // decoupling queue
    bcmp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_out),
        .empty     (q_empty)
    );

    // division and pressure correction
    bcmp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cal          (cal_reg),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_item       (q_out),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef SYNTH
    // a zero divisor always reports zero pressure
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.pressure_invalid |-> result.pressure_q24_8 == 32'd0)
        else $error("invalid pressure not forced to zero");

    // non-negative fine temperature never gives a negative temperature
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.fine_temperature[31] |-> !result.temperature_centi[15])
        else $error("temperature sign disagrees with fine temperature");

    // the queue only fills through a push
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(q_full) |-> $past(q_push))
        else $error("queue became full without a push");
`endif

endmodule

`default_nettype wire

// ===== sim/barometer_compensation_core_test.sv =====
`default_nettype none

module barometer_compensation_core_test;
    import bcmp_pkg::*;

    localparam int LATENCY_WAIT = 80;
    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 85;

    // calibration sets used by the directed table
    localparam int SEL_RESET   = 0;
    localparam int SEL_TYPICAL = 1;
    localparam int SEL_NO_DIV  = 2;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      sample_valid = 1'b0;
    logic      sample_ready;
    sample_t   sample = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    result_t   result;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    cfg_idx_t  cfg_index = CFG_T1;
    logic [31:0] cfg_data = '0;

    cal_t      cal_copy = '0;
    result_t   pending_results[$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    int        recv_stall = 0;
    bit        calm = 1'b0;

    barometer_compensation_core dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // compensation predictor: fine temperature, centi-degrees, q24.8 pressure
    function automatic result_t compensate(cal_t c, sample_t s);
        longint rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint diff, fine, cent, v, w, u, base, lo, hi, acc, d;
        longint num, nq, nr, q, sq, a9, hi9, lo9, c9, c8, f;
        result_t r;
        rt = longint'(s.raw_temperature);
        rp = longint'(s.raw_pressure);
        t1 = longint'(c.t1);
        t2 = longint'($signed(c.t2));
        t3 = longint'($signed(c.t3));
        p1 = longint'(c.p1);
        p2 = longint'($signed(c.p2_p3[15:0]));
        p3 = longint'($signed(c.p2_p3[31:16]));
        p4 = longint'($signed(c.p4_p5[15:0]));
        p5 = longint'($signed(c.p4_p5[31:16]));
        p6 = longint'($signed(c.p6_p7[15:0]));
        p7 = longint'($signed(c.p6_p7[31:16]));
        p8 = longint'($signed(c.p8_p9[15:0]));
        p9 = longint'($signed(c.p8_p9[31:16]));

        // temperature path
        diff = (rt >>> 4) - t1;
        fine = ((((rt >>> 3) - 2 * t1) * t2) >>> 11)
             + ((((diff * diff) >>> 12) * t3) >>> 14);
        cent = (fine * 5 + 128) >>> 8;
        if (cent > 32767) cent = 32767;
        if (cent < -32768) cent = -32768;

        // pressure divisor and offset
        v = fine - 128000;
        w = v * v * p6 + v * p5 * 131072 + p4 * (longint'(1) <<< 35);
        u = ((v * v * p3) >>> 8) + v * p2 * 4096;
        base = (longint'(1) <<< 47) + u;
        lo = base & 64'sh1FFFF;
        hi = base >>> 17;
        acc = hi * p1 + ((lo * p1) >>> 17);
        d = acc >>> 16;

        r.fine_temperature  = fine[31:0];
        r.temperature_centi = cent[15:0];
        r.pressure_q24_8    = '0;
        r.pressure_invalid  = 1'b0;
        if (d == 0) begin
            r.pressure_invalid = 1'b1;
        end
        else begin
            num = (1048576 - rp) * (longint'(1) <<< 31) - w;
            nq = num / d;
            nr = num % d;
            if (nq > (longint'(1) <<< 35)) begin
                q = longint'(1) <<< 46;
            end
            else if (nq < -(longint'(1) <<< 35)) begin
                q = -(longint'(1) <<< 46);
            end
            else begin
                q = nq * 3125 + (nr * 3125) / d;
                if (q > (longint'(1) <<< 46)) q = longint'(1) <<< 46;
                if (q < -(longint'(1) <<< 46)) q = -(longint'(1) <<< 46);
            end
            // second-order correction
            sq = q >>> 13;
            a9 = p9 * sq;
            hi9 = a9 >>> 25;
            lo9 = a9 - hi9 * 33554432;
            c9 = hi9 * sq + ((lo9 * sq) >>> 25);
            c8 = (p8 * q) >>> 19;
            f = ((q + c9 + c8) >>> 8) + p7 * 16;
            if (f < 0) f = 0;
            if (f > 64'sh0FFFFFFFF) f = 64'sh0FFFFFFFF;
            r.pressure_q24_8 = f[31:0];
        end
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        mismatch_count++;
    endtask

    // one register write transaction, copy kept masked to the register width
    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_T1:    cal_copy.t1    = val[15:0];
            CFG_T2:    cal_copy.t2    = val[15:0];
            CFG_T3:    cal_copy.t3    = val[15:0];
            CFG_P1:    cal_copy.p1    = val[15:0];
            CFG_P2_P3: cal_copy.p2_p3 = val;
            CFG_P4_P5: cal_copy.p4_p5 = val;
            CFG_P6_P7: cal_copy.p6_p7 = val;
            default:   cal_copy.p8_p9 = val;
        endcase
    endtask

    // all eight registers; upper bits of the short words carry noise
    task automatic load_cal(cal_t c);
        write_reg(CFG_T1, {16'($urandom), c.t1});
        write_reg(CFG_T2, {16'($urandom), c.t2});
        write_reg(CFG_T3, {16'($urandom), c.t3});
        write_reg(CFG_P1, {16'($urandom), c.p1});
        write_reg(CFG_P2_P3, c.p2_p3);
        write_reg(CFG_P4_P5, c.p4_p5);
        write_reg(CFG_P6_P7, c.p6_p7);
        write_reg(CFG_P8_P9, c.p8_p9);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_results.size() == 0);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    // one sample transaction; expectation taken at acceptance
    task automatic send(sample_t s, bit typed, result_t want);
        int gap;
        gap = gap_len();
        while (gap > 0)
        begin
            @(negedge clk);
            sample_valid <= 1'b0;
            gap--;
        end
        @(negedge clk);
        sample_valid <= 1'b1;
        sample <= s;
        do @(posedge clk); while (!sample_ready);
        pending_results.push_back(typed ? want : compensate(cal_copy, s));
    endtask

    function automatic cal_t typical_cal();
        cal_t c;
        c.t1 = 16'd27504;
        c.t2 = 16'd26435;
        c.t3 = -16'sd1000;
        c.p1 = 16'd36477;
        c.p2_p3 = {16'd3024, -16'sd10685};
        c.p4_p5 = {16'd140, 16'd2855};
        c.p6_p7 = {16'd15500, -16'sd7};
        c.p8_p9 = {16'd6000, -16'sd14600};
        return c;
    endfunction

    function automatic cal_t phase_cal(int k);
        cal_t c;
        c = typical_cal();
        case (k)
            0: ;
            1: c = '1;
            2: c = {16'h0000, 16'h8000, 16'h8000, 16'h0001,
                    32'h80008000, 32'h80008000, 32'h80008000, 32'h80008000};
            3: c = {16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF,
                    32'h7FFF7FFF, 32'h7FFF7FFF, 32'h7FFF7FFF, 32'h7FFF7FFF};
            default:
            begin
                if ($urandom_range(0, 1) == 0) begin
                    c.t1 = c.t1 + 16'($urandom_range(0, 2000)) - 16'd1000;
                    c.t2 = c.t2 + 16'($urandom_range(0, 2000)) - 16'd1000;
                    c.p1 = c.p1 + 16'($urandom_range(0, 2000)) - 16'd1000;
                    c.p8_p9 = $urandom;
                end
                else begin
                    c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                end
            end
        endcase
        return c;
    endfunction

    function automatic logic [19:0] near(int centre);
        int x;
        x = centre + $urandom_range(0, 131072) - 65536;
        if (x < 0) x = 0;
        if (x > 1048575) x = 1048575;
        return 20'(x);
    endfunction

    typedef struct {
        int      sel;
        sample_t s;
        bit      typed;
        result_t want;
    } row_t;

    // directed table: reset calibration gives a zero divisor whatever the readings
    row_t rows[] = '{
        '{SEL_RESET, '{20'd0, 20'd0}, 1'b1, '{32'sd0, 16'sd0, 32'd0, 1'b1}},
        '{SEL_RESET, '{20'hFFFFF, 20'hFFFFF}, 1'b1, '{32'sd0, 16'sd0, 32'd0, 1'b1}},
        '{SEL_RESET, '{20'hFFFFF, 20'd0}, 1'b1, '{32'sd0, 16'sd0, 32'd0, 1'b1}},
        '{SEL_RESET, '{20'd0, 20'hFFFFF}, 1'b1, '{32'sd0, 16'sd0, 32'd0, 1'b1}},
        '{SEL_RESET, '{20'hAAAAA, 20'h55555}, 1'b1, '{32'sd0, 16'sd0, 32'd0, 1'b1}},
        '{SEL_TYPICAL, '{20'd519888, 20'd415148}, 1'b0, '0},
        '{SEL_TYPICAL, '{20'd0, 20'd0}, 1'b0, '0},
        '{SEL_TYPICAL, '{20'hFFFFF, 20'hFFFFF}, 1'b0, '0},
        '{SEL_TYPICAL, '{20'd0, 20'hFFFFF}, 1'b0, '0},
        '{SEL_TYPICAL, '{20'hFFFFF, 20'd0}, 1'b0, '0},
        '{SEL_TYPICAL, '{20'd440064, 20'd415148}, 1'b0, '0},
        '{SEL_TYPICAL, '{20'd519888, 20'd524288}, 1'b0, '0},
        '{SEL_TYPICAL, '{20'd1, 20'd1}, 1'b0, '0},
        '{SEL_TYPICAL, '{20'd600000, 20'd300000}, 1'b0, '0},
        '{SEL_NO_DIV, '{20'd519888, 20'd415148}, 1'b0, '0},
        '{SEL_NO_DIV, '{20'hFFFFF, 20'd0}, 1'b0, '0},
        '{SEL_NO_DIV, '{20'd0, 20'hFFFFF}, 1'b0, '0}
    };

    // stimulus
    initial
    begin
        int cur_sel;
        cal_t c;
        sample_t s;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        cur_sel = SEL_RESET;
        foreach (rows[i])
        begin
            if (rows[i].sel != cur_sel) begin
                @(negedge clk);
                sample_valid <= 1'b0;
                drain();
                cur_sel = rows[i].sel;
                c = typical_cal();
                if (cur_sel == SEL_NO_DIV) c.p1 = 16'd0;
                load_cal(c);
            end
            send(rows[i].s, rows[i].typed, rows[i].want);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            @(negedge clk);
            sample_valid <= 1'b0;
            drain();
            calm = (ph % 3 == 2);
            load_cal(phase_cal(ph));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold the sender until the pipe is empty once
                if (ph == 5 && n == 40) begin
                    @(negedge clk);
                    sample_valid <= 1'b0;
                    wait (pending_results.size() == 0);
                end
                if ($urandom_range(0, 9) < 7) begin
                    s.raw_temperature = near(519888);
                    s.raw_pressure    = near(415148);
                end
                else begin
                    s.raw_temperature = 20'($urandom);
                    s.raw_pressure    = 20'($urandom);
                end
                send(s, 1'b0, '0);
            end
        end
        @(negedge clk);
        sample_valid <= 1'b0;
        drain();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end
        else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (recv_stall == 0) begin
            result_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) recv_stall = gap_len();
        end
        else begin
            result_ready <= 1'b0;
            recv_stall--;
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result transaction", 1, 0);
            end
            else begin
                want = pending_results.pop_front();
                if (result.fine_temperature !== want.fine_temperature)
                    report_mismatch("fine_temperature", result.fine_temperature,
                                    want.fine_temperature);
                if (result.temperature_centi !== want.temperature_centi)
                    report_mismatch("temperature_centi", result.temperature_centi,
                                    want.temperature_centi);
                if (result.pressure_q24_8 !== want.pressure_q24_8)
                    report_mismatch("pressure_q24_8", result.pressure_q24_8,
                                    want.pressure_q24_8);
                if (result.pressure_invalid !== want.pressure_invalid)
                    report_mismatch("pressure_invalid", result.pressure_invalid,
                                    want.pressure_invalid);
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end
        else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/bcmp_pkg.sv
hdl/bcmp_front.sv
hdl/bcmp_fifo.sv
hdl/bcmp_back.sv
hdl/barometer_compensation_core.sv
sim/barometer_compensation_core_test.sv
